// ===== design/hcbp_pkg.sv =====
package hcbp_pkg;

	// request modes
	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_ENCODE = 2'd1,
		MODE_FINISH = 2'd2
	} mode_t;

	localparam int CODE_W      = 32;
	localparam int LEN_W       = 6;
	localparam int BYTE_W      = 8;
	localparam int PEND_W      = 7;
	localparam int CNT_W       = 3;
	// pending count plus longest code, up to 39 for codes of at most 32 bits
	localparam int TOT_W       = 7;
	// pending bits plus a code shifted by up to seven places
	localparam int ACC_W       = 40;
	// power of two, pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;

	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

	// work item between the front and the packer
	typedef struct packed {
		logic              fin;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

endpackage

// ===== design/hcbp_cmd_if.sv =====
interface hcbp_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] symbol;
	logic [31:0] code_word;
	logic [5:0] code_length;

	modport source (output valid, output mode, output symbol, output code_word,
		output code_length, input ready);
	modport sink (input valid, input mode, input symbol, input code_word,
		input code_length, output ready);
endinterface

// ===== design/hcbp_byte_if.sv =====
interface hcbp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== design/hcbp_front.sv =====
module hcbp_front #(
	parameter int ALPHABET     = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	hcbp_cmd_if.sink         cmd,
	output logic             push,
	output hcbp_pkg::entry_t push_entry,
	input  logic             q_full
);
	import hcbp_pkg::*;

	localparam int DEPTH  = (ALPHABET < 256) ? ALPHABET : 256;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_LEN);

	logic [CODE_W+LEN_W-1:0] code_mem [DEPTH];
	logic [DEPTH-1:0]        filled_q;

	logic              valid_s1;
	logic              fin_s1;
	logic              hit_s1;
	logic [CODE_W-1:0] code_s1;
	logic [LEN_W-1:0]  len_s1;

	mode_t             mode;
	logic              sym_ok;
	logic              accept;
	logic              enter_s1;
	logic              load_we;
	logic              need_push;
	logic              s1_go;
	logic [ADDR_W-1:0] addr;
	logic [LEN_W-1:0]  len_sat;
	logic [CODE_W-1:0] code_mask;

	// classify the incoming request
	always_comb begin
		mode     = mode_t'(cmd.mode);
		sym_ok   = {24'd0, cmd.symbol} < 32'(ALPHABET);
		addr     = cmd.symbol[ADDR_W-1:0];
		enter_s1 = 1'b0;
		load_we  = 1'b0;
		case (mode)
			MODE_LOAD: begin
				load_we = accept && sym_ok;
			end
			MODE_ENCODE: begin
				enter_s1 = sym_ok;
			end
			MODE_FINISH: begin
				enter_s1 = 1'b1;
			end
			default: begin
				enter_s1 = 1'b0;
			end
		endcase
	end

	// saturate the length and clear bits above it
	always_comb begin
		len_sat   = (cmd.code_length > MAX_LEN) ? MAX_LEN : cmd.code_length;
		code_mask = (len_sat >= LEN_W'(CODE_W)) ? '1 : ((CODE_W'(1) << len_sat) - CODE_W'(1));
	end

	// stage one hands work to the queue, zero-length codes vanish here
	assign need_push  = fin_s1 || (hit_s1 && (len_s1 != '0));
	assign s1_go      = valid_s1 && (!need_push || !q_full);
	assign cmd.ready  = !valid_s1 || s1_go;
	assign accept     = cmd.valid && cmd.ready;
	assign push       = s1_go && need_push;
	assign push_entry = '{fin: fin_s1, code: code_s1, len: len_s1};

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= enter_s1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// written entries, others read as length zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (load_we) begin
			filled_q[addr] <= 1'b1;
		end
	end

	// code table and its registered read
	always_ff @(posedge clk) begin
		if (load_we) begin
			code_mem[addr] <= {len_sat, cmd.code_word & code_mask};
		end
		if (accept && enter_s1) begin
			{len_s1, code_s1} <= code_mem[addr];
			hit_s1            <= filled_q[addr];
			fin_s1            <= (mode == MODE_FINISH);
		end
	end

endmodule

// ===== design/hcbp_queue.sv =====
module hcbp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hcbp_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output hcbp_pkg::entry_t head,
	output logic             empty
);
	import hcbp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;

	assign full  = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== design/hcbp_back.sv =====
module hcbp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hcbp_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	hcbp_byte_if.source      stream
);
	import hcbp_pkg::*;

	logic              busy_q;
	logic [ACC_W-1:0]  work_acc_q;
	logic [TOT_W-1:0]  work_tot_q;
	logic [PEND_W-1:0] pend_bits_q;
	logic [CNT_W-1:0]  pend_cnt_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic [BYTE_W-1:0] pad_byte;
	logic [ACC_W-1:0]  fresh_acc;
	logic [TOT_W-1:0]  fresh_tot;
	logic [ACC_W-1:0]  cur_acc;
	logic [TOT_W-1:0]  cur_tot;
	logic [TOT_W-1:0]  rem;
	logic [ACC_W-1:0]  shifted;
	logic              src_valid;
	logic              out_free;
	logic              emit;
	logic              absorb;
	logic              is_last;

	// merge the head item with the pending bits
	always_comb begin
		pad_byte = ASCII_ZERO + 8'(BYTE_W) - 8'(pend_cnt_q);
		if (head.fin) begin
			if (pend_cnt_q == '0) begin
				fresh_acc = ACC_W'(ASCII_ZERO);
				fresh_tot = TOT_W'(BYTE_W);
			end else begin
				fresh_acc = ACC_W'({pad_byte, 1'b0, pend_bits_q});
				fresh_tot = TOT_W'(2 * BYTE_W);
			end
		end else begin
			fresh_acc = ACC_W'(pend_bits_q) | (ACC_W'(head.code) << pend_cnt_q);
			fresh_tot = TOT_W'(pend_cnt_q) + TOT_W'(head.len);
		end
	end

	// one byte a cycle from the current item while the output register is free
	always_comb begin
		cur_acc   = busy_q ? work_acc_q : fresh_acc;
		cur_tot   = busy_q ? work_tot_q : fresh_tot;
		src_valid = busy_q || !empty;
		out_free  = !out_valid_q || stream.ready;
		rem       = cur_tot - TOT_W'(BYTE_W);
		is_last   = rem < TOT_W'(BYTE_W);
		shifted   = cur_acc >> BYTE_W;
		emit      = src_valid && out_free && (cur_tot >= TOT_W'(BYTE_W));
		absorb    = !busy_q && !empty && (cur_tot < TOT_W'(BYTE_W));
		pop       = !busy_q && !empty && (emit || absorb);
	end

	// pending buffer and multi-byte tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (absorb) begin
			pend_bits_q <= cur_acc[PEND_W-1:0];
			pend_cnt_q  <= cur_tot[CNT_W-1:0];
		end else if (emit) begin
			if (is_last) begin
				busy_q      <= 1'b0;
				pend_bits_q <= shifted[PEND_W-1:0];
				pend_cnt_q  <= rem[CNT_W-1:0];
			end else begin
				busy_q <= 1'b1;
			end
		end
	end

	// remaining bytes of a long item
	always_ff @(posedge clk) begin
		if (emit && !is_last) begin
			work_acc_q <= shifted;
			work_tot_q <= rem;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_acc[BYTE_W-1:0];
			out_last_q <= is_last;
		end
	end

	assign stream.valid    = out_valid_q;
	assign stream.out_byte = out_byte_q;
	assign stream.last     = out_last_q;

endmodule

// ===== design/huffman_code_bit_packer_unit.sv =====
// Huffman code bit packer.
// cmd carries one request per handshake: a table load (mode 0), an encode of
// one symbol (mode 1) or a stream finish (mode 2). stream returns packed bytes,
// first code bit in the lowest free bit, with last set on the final byte that
// a request produced. Loads and encodes that complete no byte return nothing.
// The front takes one request per cycle unless the queue is full: it writes
// or reads the code table and drops loads, zero-length codes and symbols
// beyond the alphabet. A four-entry queue feeds the packer, which emits one
// byte per cycle while stream accepts; an encode holds it until every byte it
// completes is out, up to (7 + MAX_CODE_LEN) / 8, and a finish emits one or
// two bytes. The single byte port sets the sustained rate. A request's first
// byte reaches stream through stage one, the queue and the output register.
// Reset empties the pipeline and the pending bits and marks every table entry
// as unwritten, which reads as length zero; no clearing pass is needed.
// When stream stalls the output register holds, the packer and then the
// queue fill, and cmd.ready drops; no byte is lost or repeated.
module huffman_code_bit_packer_unit #(
	parameter int ALPHABET     = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input logic         clk,
	input logic         arst_n,
	hcbp_cmd_if.sink    cmd,
	hcbp_byte_if.source stream
);
	import hcbp_pkg::*;

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;
	entry_t q_in;
	entry_t q_head;

	// request intake and code table
	hcbp_front #(
		.ALPHABET     (ALPHABET),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push       (q_push),
		.push_entry (q_in),
		.q_full     (q_full)
	);

	// decoupling queue
	hcbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	// bit packer and output register
	hcbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (q_pop),
		.stream (stream)
	);

	// front never overruns the queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into a full queue");

	// packer only takes real work
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from an empty queue");

	// a full queue with no pop stays full and blocks the next push
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !q_pop) |=> q_full)
		else $error("queue level lost an entry");

endmodule
